// ===== rtl/gbn_pkg.sv =====
// ----------------------------------------------------------------------------
// gbn_pkg
// shared constants, payload types and kernel weights of the 9x9 blur
// ----------------------------------------------------------------------------
package gbn_pkg;

  // line store geometry
  localparam int LINE_MAX  = 2048;
  localparam int LINE_AW   = $clog2(LINE_MAX);
  localparam int ROW_SLOTS = 16;
  localparam int SLOT_AW   = $clog2(ROW_SLOTS);
  localparam int RAM_DEPTH = ROW_SLOTS * LINE_MAX;
  localparam int RAM_AW    = SLOT_AW + LINE_AW;
  localparam int PIX_W     = 24;

  // kernel
  localparam int RADIUS = 4;
  localparam int TAPS   = 2 * RADIUS + 1;
  localparam int KIDX_W = 4;
  localparam int WT_W   = 6;
  localparam int KSUM_W = 11;
  localparam int SUM_W  = 19;
  localparam int QUOT_W = 8;

  // register file
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 2;
  localparam int WIDTH_W   = 12;
  localparam int HEIGHT_W  = 13;
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;
  localparam logic [WIDTH_W-1:0]   WIDTH_RST  = 12'd640;
  localparam logic [HEIGHT_W-1:0]  HEIGHT_RST = 13'd480;

  // counters
  localparam int ROW_CNT_W = 13;
  localparam int POS_W     = 24;
  localparam int LAT_W     = 14;

  localparam logic [WT_W-1:0] KERN [TAPS][TAPS] = '{
    '{6'd1,  6'd3,  6'd5,  6'd7,  6'd10, 6'd7,  6'd5,  6'd3,  6'd1},
    '{6'd3,  6'd13, 6'd16, 6'd19, 6'd22, 6'd19, 6'd16, 6'd13, 6'd3},
    '{6'd5,  6'd16, 6'd25, 6'd28, 6'd31, 6'd28, 6'd25, 6'd16, 6'd5},
    '{6'd7,  6'd19, 6'd28, 6'd34, 6'd37, 6'd34, 6'd28, 6'd19, 6'd7},
    '{6'd10, 6'd22, 6'd31, 6'd37, 6'd40, 6'd37, 6'd31, 6'd22, 6'd10},
    '{6'd7,  6'd19, 6'd28, 6'd34, 6'd37, 6'd34, 6'd28, 6'd19, 6'd7},
    '{6'd5,  6'd16, 6'd25, 6'd28, 6'd31, 6'd28, 6'd25, 6'd16, 6'd5},
    '{6'd3,  6'd13, 6'd16, 6'd19, 6'd22, 6'd19, 6'd16, 6'd13, 6'd3},
    '{6'd1,  6'd3,  6'd5,  6'd7,  6'd10, 6'd7,  6'd5,  6'd3,  6'd1}
  };

  typedef struct packed {
    logic       drain_tick;
    logic [7:0] sample_a;
    logic [7:0] sample_b;
    logic [7:0] sample_c;
  } in_t;

  typedef struct packed {
    logic [7:0] blur_a;
    logic [7:0] blur_b;
    logic [7:0] blur_c;
    logic       frame_end;
  } out_t;

endpackage

// ===== rtl/gbn_in_if.sv =====
// ----------------------------------------------------------------------------
// gbn_in_if
// pixel input channel: valid, ready and one pixel word
// ----------------------------------------------------------------------------
interface gbn_in_if;
  logic        valid;
  logic        ready;
  gbn_pkg::in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/gbn_out_if.sv =====
// ----------------------------------------------------------------------------
// gbn_out_if
// blurred pixel output channel: valid, ready and one result word
// ----------------------------------------------------------------------------
interface gbn_out_if;
  logic          valid;
  logic          ready;
  gbn_pkg::out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/gbn_ram.sv =====
// ----------------------------------------------------------------------------
// gbn_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module gbn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/gaussian_9x9_border_normalized.sv =====
// ----------------------------------------------------------------------------
// gaussian_9x9_border_normalized
// streaming 9x9 gaussian blur, border taps dropped and weights renormalized
// ----------------------------------------------------------------------------
// usage
//   pix_i takes one word per pixel in raster order; drain_tick words after the
//   last pixel flush the outputs still pending. blur_o gives one blurred pixel
//   per word once 4*W+4 words of the frame are in, frame_end on the last one.
//   the cfg port (cfg_we_i, cfg_idx_i, cfg_data_i) sets mode, width, height;
//   a write restarts the frame; the user must write only while the block is
//   idle, the block itself does not enforce it. a word that makes no output
//   leaves the block ready; one that makes an output holds off input while
//   the tap scan reads the T kernel taps inside the image (81 inside, fewer
//   near the border, down to 1 in a one-pixel frame) one pixel per cycle
//   through the line store's single read port and then an 8-step restoring
//   divide by the in-image weight sum runs.
// reset and stalls
//   reset restores gray mode, 640x480 and a fresh frame; the line store is
//   not cleared, rows are rewritten before any tap can see them.
//   a finished result waits in the output register; the next word is taken
//   meanwhile, and the block also holds off when a second result is ready.
// ----------------------------------------------------------------------------
module gaussian_9x9_border_normalized (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  gbn_in_if.sink                          pix_i,
  gbn_out_if.source                       blur_o,
  input  logic                            cfg_we_i,
  input  logic [gbn_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [gbn_pkg::CFG_W-1:0]       cfg_data_i
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_FLUSH = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  localparam int LAW = gbn_pkg::LINE_AW;
  localparam int KW  = gbn_pkg::KIDX_W;
  localparam int SW  = gbn_pkg::SUM_W;

  // config registers
  logic                          mode_q;
  logic [gbn_pkg::WIDTH_W-1:0]   img_w_q;
  logic [gbn_pkg::HEIGHT_W-1:0]  img_h_q;

  // effective geometry
  logic [gbn_pkg::WIDTH_W-1:0]   w_eff;
  logic [gbn_pkg::HEIGHT_W-1:0]  h_eff;
  logic [gbn_pkg::LAT_W-1:0]     lat;

  assign w_eff = (img_w_q == '0) ? gbn_pkg::WIDTH_W'(1) :
                 (img_w_q > gbn_pkg::WIDTH_W'(gbn_pkg::LINE_MAX)) ?
                 gbn_pkg::WIDTH_W'(gbn_pkg::LINE_MAX) : img_w_q;
  assign h_eff = (img_h_q == '0) ? gbn_pkg::HEIGHT_W'(1) : img_h_q;
  assign lat   = {w_eff, 2'b00} + gbn_pkg::LAT_W'(gbn_pkg::RADIUS);

  // stream position counters
  logic [LAW-1:0]                col_q;
  logic [gbn_pkg::ROW_CNT_W-1:0] row_q;
  logic [gbn_pkg::POS_W-1:0]     pos_q;
  logic [LAW-1:0]                ox_q;
  logic [gbn_pkg::WIDTH_W-1:0]   oy_q;

  logic [2:0] state_q;

  // tap scan registers
  logic [LAW-1:0]               cur_x_q;
  logic [gbn_pkg::WIDTH_W-1:0]  cur_y_q;
  logic                         last_q;
  logic [KW-1:0]                ky_q, kx_q, ky_lo_q, ky_hi_q, kx_lo_q, kx_hi_q;
  logic                         tap_v_q;
  logic [KW-1:0]                tap_ky_q, tap_kx_q;
  logic [SW-1:0]                sum_a_q, sum_b_q, sum_c_q;
  logic [gbn_pkg::KSUM_W-1:0]   ksum_q;
  logic [2:0]                   div_i_q;
  logic [gbn_pkg::QUOT_W-1:0]   q_a_q, q_b_q, q_c_q;

  // output register
  logic          out_valid_q;
  gbn_pkg::out_t out_q;

  // input decode
  logic accept, pix_phase, step, emit, last_px;
  logic cfg_hit;

  assign pix_i.ready = (state_q == ST_IDLE);
  assign accept      = pix_i.valid & pix_i.ready;
  assign pix_phase   = (row_q < h_eff);
  // drain words are ignored while pixels of the frame are still due
  assign step        = accept & ~(pix_phase & pix_i.data.drain_tick);
  assign emit        = (pos_q >= gbn_pkg::POS_W'(lat));
  assign last_px     = emit && ({1'b0, ox_q} == w_eff - 1'b1) &&
                       ({1'b0, oy_q} == h_eff - 1'b1);
  assign cfg_hit     = cfg_we_i && ((cfg_idx_i == gbn_pkg::REG_MODE) ||
                       (cfg_idx_i == gbn_pkg::REG_WIDTH) ||
                       (cfg_idx_i == gbn_pkg::REG_HEIGHT));

  // tap window bounds of the next output, clipped at the image border
  logic [gbn_pkg::HEIGHT_W-1:0] rem_y;
  logic [gbn_pkg::WIDTH_W-1:0]  rem_x;
  logic [KW-1:0]                ky_lo, ky_hi, kx_lo, kx_hi;

  assign rem_y = h_eff - 1'b1 - {1'b0, oy_q};
  assign rem_x = w_eff - 1'b1 - {1'b0, ox_q};
  assign ky_lo = (oy_q < gbn_pkg::WIDTH_W'(4)) ? KW'(4) - oy_q[KW-1:0] : '0;
  assign ky_hi = (rem_y < gbn_pkg::HEIGHT_W'(4)) ? KW'(4) + rem_y[KW-1:0] : KW'(8);
  assign kx_lo = (ox_q < LAW'(4)) ? KW'(4) - {1'b0, ox_q[KW-2:0]} : '0;
  assign kx_hi = (rem_x < gbn_pkg::WIDTH_W'(4)) ? KW'(4) + rem_x[KW-1:0] : KW'(8);

  // line store: slot = row mod 16, holds every row a window can reach
  logic                         ram_we, ram_re;
  logic [gbn_pkg::RAM_AW-1:0]   ram_waddr, ram_raddr;
  logic [gbn_pkg::PIX_W-1:0]    ram_wdata, ram_rdata;
  logic [gbn_pkg::SLOT_AW-1:0]  rd_slot;
  logic [LAW-1:0]               rd_col;

  assign ram_we    = step & pix_phase;
  assign ram_waddr = {row_q[gbn_pkg::SLOT_AW-1:0], col_q};
  assign ram_wdata = mode_q ?
                     {pix_i.data.sample_c, pix_i.data.sample_b, pix_i.data.sample_a} :
                     {16'd0, pix_i.data.sample_a};
  assign ram_re    = (state_q == ST_SCAN);
  assign rd_slot   = cur_y_q[gbn_pkg::SLOT_AW-1:0] + gbn_pkg::SLOT_AW'(ky_q)
                     - gbn_pkg::SLOT_AW'(gbn_pkg::RADIUS);
  assign rd_col    = cur_x_q + LAW'(kx_q) - LAW'(gbn_pkg::RADIUS);
  assign ram_raddr = {rd_slot, rd_col};

  gbn_ram #(
    .WIDTH (gbn_pkg::PIX_W),
    .DEPTH (gbn_pkg::RAM_DEPTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // weighted products of the tap that came back from the store
  logic [gbn_pkg::WT_W-1:0] wt;
  logic [SW-1:0]            prod_a, prod_b, prod_c;

  assign wt     = gbn_pkg::KERN[tap_ky_q][tap_kx_q];
  assign prod_a = SW'(ram_rdata[7:0])   * SW'(wt);
  assign prod_b = SW'(ram_rdata[15:8])  * SW'(wt);
  assign prod_c = SW'(ram_rdata[23:16]) * SW'(wt);

  // divide step: trial divisor ksum << bit
  logic [SW-1:0] trial;
  assign trial = SW'(ksum_q) << div_i_q;

  logic out_load;
  assign out_load = (state_q == ST_DONE) && (!out_valid_q || blur_o.ready);

  // config registers and stream counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 1'b0;
      img_w_q <= gbn_pkg::WIDTH_RST;
      img_h_q <= gbn_pkg::HEIGHT_RST;
      col_q   <= '0;
      row_q   <= '0;
      pos_q   <= '0;
      ox_q    <= '0;
      oy_q    <= '0;
    end else if (cfg_hit) begin
      case (cfg_idx_i)
        gbn_pkg::REG_MODE:   mode_q  <= cfg_data_i[0];
        gbn_pkg::REG_WIDTH:  img_w_q <= cfg_data_i[gbn_pkg::WIDTH_W-1:0];
        gbn_pkg::REG_HEIGHT: img_h_q <= cfg_data_i;
        default: ;
      endcase
      col_q <= '0;
      row_q <= '0;
      pos_q <= '0;
      ox_q  <= '0;
      oy_q  <= '0;
    end else if (step) begin
      if (last_px) begin
        // frame done, counters back to the start
        col_q <= '0;
        row_q <= '0;
        pos_q <= '0;
        ox_q  <= '0;
        oy_q  <= '0;
      end else begin
        pos_q <= pos_q + 1'b1;
        if ({1'b0, col_q} + 1'b1 >= w_eff) begin
          col_q <= '0;
          row_q <= row_q + 1'b1;
        end else begin
          col_q <= col_q + 1'b1;
        end
        if (emit) begin
          if ({1'b0, ox_q} + 1'b1 >= w_eff) begin
            ox_q <= '0;
            oy_q <= oy_q + 1'b1;
          end else begin
            ox_q <= ox_q + 1'b1;
          end
        end
      end
    end
  end

  // sequencer: scan taps, divide, hand to the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      tap_v_q <= 1'b0;
    end else begin
      tap_v_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (step && emit) begin
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          tap_v_q <= 1'b1;
          if (kx_q == kx_hi_q && ky_q == ky_hi_q) begin
            state_q <= ST_FLUSH;
          end
        end
        ST_FLUSH: state_q <= ST_DIV;
        ST_DIV: begin
          if (div_i_q == '0) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath of the scan and divide
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        cur_x_q <= ox_q;
        cur_y_q <= oy_q;
        last_q  <= last_px;
        ky_lo_q <= ky_lo;
        ky_hi_q <= ky_hi;
        kx_lo_q <= kx_lo;
        kx_hi_q <= kx_hi;
        ky_q    <= ky_lo;
        kx_q    <= kx_lo;
        sum_a_q <= '0;
        sum_b_q <= '0;
        sum_c_q <= '0;
        ksum_q  <= '0;
      end
      ST_SCAN: begin
        tap_ky_q <= ky_q;
        tap_kx_q <= kx_q;
        if (kx_q == kx_hi_q) begin
          kx_q <= kx_lo_q;
          ky_q <= ky_q + 1'b1;
        end else begin
          kx_q <= kx_q + 1'b1;
        end
        div_i_q <= 3'd7;
      end
      ST_DIV: begin
        div_i_q <= div_i_q - 1'b1;
        if (sum_a_q >= trial) begin
          sum_a_q          <= sum_a_q - trial;
          q_a_q[div_i_q]   <= 1'b1;
        end else begin
          q_a_q[div_i_q]   <= 1'b0;
        end
        if (sum_b_q >= trial) begin
          sum_b_q          <= sum_b_q - trial;
          q_b_q[div_i_q]   <= 1'b1;
        end else begin
          q_b_q[div_i_q]   <= 1'b0;
        end
        if (sum_c_q >= trial) begin
          sum_c_q          <= sum_c_q - trial;
          q_c_q[div_i_q]   <= 1'b1;
        end else begin
          q_c_q[div_i_q]   <= 1'b0;
        end
      end
      default: ;
    endcase
    // accumulate the tap read in the previous cycle
    if (tap_v_q) begin
      sum_a_q <= sum_a_q + prod_a;
      sum_b_q <= sum_b_q + prod_b;
      sum_c_q <= sum_c_q + prod_c;
      ksum_q  <= ksum_q + gbn_pkg::KSUM_W'(wt);
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (blur_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.blur_a    <= q_a_q;
      out_q.blur_b    <= q_b_q;
      out_q.blur_c    <= q_c_q;
      out_q.frame_end <= last_q;
    end
  end

  assign blur_o.valid = out_valid_q;
  assign blur_o.data  = out_q;

  // checks
  a_ksum_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (ksum_q != '0))
    else $error("divide started with empty weight sum");

  a_scan_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (ky_q >= ky_lo_q && ky_q <= ky_hi_q &&
                              kx_q >= kx_lo_q && kx_q <= kx_hi_q))
    else $error("tap scan left the clipped window");

  a_done_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && blur_o.ready) |=> (blur_o.valid && state_q == ST_IDLE))
    else $error("finished result not loaded into the output register");

endmodule

// ===== tb/gaussian_9x9_border_normalized_checker.sv =====
// ----------------------------------------------------------------------------
// gaussian_9x9_border_normalized_checker
// watches the pixel, blur and cfg ports, predicts each blurred word and
// compares it field by field with what the block delivers
// ----------------------------------------------------------------------------
module gaussian_9x9_border_normalized_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  gbn_in_if                             pix_i,
  gbn_out_if                            blur_i,
  input  logic                          cfg_we_i,
  input  logic [gbn_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [gbn_pkg::CFG_W-1:0]     cfg_data_i,
  output int                            fail_count_o,
  output int                            pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import gbn_pkg::*;

  localparam int LINE = 2048;

  // predicted copy of the block state
  logic                three_ch;
  logic [11:0]         img_w;
  logic [12:0]         img_h;
  logic [23:0]         line_mem [8*LINE];
  logic [23:0]         win [81];
  int unsigned         col_cnt;
  int unsigned         row_cnt;
  out_t                blur_q [$];

  function automatic bit blur_step(input in_t w, output out_t r);
    int unsigned ew, eh, lat, n, v, o, y, x, ksum;
    int unsigned acc [3];
    int          ry, rx;
    logic [23:0] col [9];
    logic [23:0] p;
    logic [23:0] pix;
    int unsigned wt;
    ew = (img_w == 0) ? 1 : img_w;
    if (ew > LINE) ew = LINE;
    eh = (img_h == 0) ? 1 : img_h;
    n = ew * eh;
    lat = 4 * ew + 4;
    r = '0;
    if (row_cnt < eh) begin
      if (w.drain_tick) return 0;
      pix = three_ch ? {w.sample_c, w.sample_b, w.sample_a} : {16'h0, w.sample_a};
      for (int t = 0; t < 8; t++) col[t] = line_mem[((row_cnt + t) & 7) * LINE + col_cnt];
      col[8] = pix;
      line_mem[(row_cnt & 7) * LINE + col_cnt] = pix;
    end else begin
      for (int t = 0; t < 9; t++) col[t] = '0;
    end
    for (int j = 8; j > 0; j--)
      for (int t = 0; t < 9; t++) win[j*9+t] = win[(j-1)*9+t];
    for (int t = 0; t < 9; t++) win[t] = col[t];
    v = row_cnt * ew + col_cnt;
    col_cnt++;
    if (col_cnt >= ew) begin
      col_cnt = 0;
      row_cnt++;
    end
    if (v < lat) return 0;
    o = v - lat;
    y = o / ew;
    x = o % ew;
    ksum = 0;
    acc = '{0, 0, 0};
    for (int dy = -4; dy <= 4; dy++) begin
      ry = int'(y) + dy;
      if (ry < 0 || ry >= int'(eh)) continue;
      for (int dx = -4; dx <= 4; dx++) begin
        rx = int'(x) + dx;
        if (rx < 0 || rx >= int'(ew)) continue;
        if (y + 4 < eh) p = win[(4 - dx) * 9 + 4 + dy];
        else p = line_mem[(ry & 7) * LINE + rx];
        wt = KERN[dy+4][dx+4];
        ksum += wt;
        for (int ch = 0; ch < 3; ch++) acc[ch] += ((p >> (8 * ch)) & 8'hff) * wt;
      end
    end
    r.blur_a = acc[0] / ksum;
    if (three_ch) begin
      r.blur_b = acc[1] / ksum;
      r.blur_c = acc[2] / ksum;
    end
    r.frame_end = (o + 1 == n);
    if (o + 1 >= n) begin
      col_cnt = 0;
      row_cnt = 0;
    end
    return 1;
  endfunction

  assign pending_o = blur_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    out_t exp_w, got;
    int   fails;
    if (!rst_ni) begin
      three_ch = 1'b0;
      img_w = WIDTH_RST;
      img_h = HEIGHT_RST;
      col_cnt = 0;
      row_cnt = 0;
      for (int i = 0; i < 81; i++) win[i] = '0;
      blur_q.delete();
      fail_count_o <= 0;
    end else begin
      fails = 0;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_MODE:   three_ch = cfg_data_i[0];
          REG_WIDTH:  img_w = cfg_data_i[11:0];
          REG_HEIGHT: img_h = cfg_data_i[12:0];
          default: ;
        endcase
        if (cfg_idx_i inside {REG_MODE, REG_WIDTH, REG_HEIGHT}) begin
          col_cnt = 0;
          row_cnt = 0;
        end
      end
      if (pix_i.valid && pix_i.ready) begin
        if (blur_step(pix_i.data, exp_w)) blur_q.push_back(exp_w);
      end
      if (blur_i.valid && blur_i.ready) begin
        got = blur_i.data;
        if (blur_q.size() == 0) begin
          $error("unexpected blur word %h", got);
          fails++;
        end else begin
          exp_w = blur_q.pop_front();
          if (got.blur_a !== exp_w.blur_a) begin
            $error("blur_a expected %0d actual %0d", exp_w.blur_a, got.blur_a);
            fails++;
          end
          if (got.blur_b !== exp_w.blur_b) begin
            $error("blur_b expected %0d actual %0d", exp_w.blur_b, got.blur_b);
            fails++;
          end
          if (got.blur_c !== exp_w.blur_c) begin
            $error("blur_c expected %0d actual %0d", exp_w.blur_c, got.blur_c);
            fails++;
          end
          if (got.frame_end !== exp_w.frame_end) begin
            $error("frame_end expected %0d actual %0d", exp_w.frame_end, got.frame_end);
            fails++;
          end
        end
      end
      fail_count_o <= fail_count_o + fails;
    end
  end
endmodule

// ===== tb/gaussian_9x9_border_normalized_tb.sv =====
// ----------------------------------------------------------------------------
// gaussian_9x9_border_normalized_tb
// streams whole frames of random and extreme pixels through the blur under
// several geometries and modes, with random idling on both channels; the
// checker beside the block predicts and compares every blurred word
// ----------------------------------------------------------------------------
module gaussian_9x9_border_normalized_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gbn_pkg::*;

  localparam int QUIET_LIMIT = 5000;  // cycles with no word moving
  localparam int SETTLE      = 200;   // margin for the longest result, a full-window scan and divide

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = REG_MODE;
  logic [CFG_W-1:0]     cfg_data_i = '0;
  int                   fail_count;
  int                   pending;

  gbn_in_if  pix_if ();
  gbn_out_if blur_if ();

  // idle percentages, changed by the stimulus per phase
  int tx_idle = 21;
  int rx_idle = 61;
  int hold_left = 0;   // long receiver hold-off, counted down below
  int items_sent = 0;

  // what the stimulus believes the geometry is
  int unsigned cur_w = 640;
  int unsigned cur_h = 480;

  always #2 clk_i = ~clk_i;

  gaussian_9x9_border_normalized u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pix_i      (pix_if.sink),
    .blur_o     (blur_if.source),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  gaussian_9x9_border_normalized_checker u_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pix_i        (pix_if),
    .blur_i       (blur_if),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    pix_if.valid = 1'b0;
    pix_if.data  = '0;
    blur_if.ready = 1'b0;
  end

  // receiver: random stalls, plus the long hold-off that fills the block
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      blur_if.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      blur_if.ready <= ($urandom_range(99) >= rx_idle);
    end
  end

  // watchdog on cycles where nothing is accepted
  always @(posedge clk_i) begin
    int quiet;
    if (!rst_ni || (pix_if.valid && pix_if.ready) || (blur_if.valid && blur_if.ready))
      quiet = 0;
    else
      quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // offer one word, with random gaps first; valid stays up between words unless a gap is drawn
  task automatic push_word(input in_t w);
    while ($urandom_range(99) < tx_idle) begin
      pix_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix_if.valid <= 1'b1;
    pix_if.data  <= w;
    @(posedge clk_i);
    while (!pix_if.ready) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic wait_idle();
    pix_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    // a word with no result never enters the scan; this wait is a margin
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // all three registers, only while idle
  task automatic configure(input bit mode, input int unsigned w, input int unsigned h);
    wait_idle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_MODE;
    cfg_data_i <= CFG_W'(mode);
    @(posedge clk_i);
    cfg_idx_i  <= REG_WIDTH;
    cfg_data_i <= CFG_W'(w);
    @(posedge clk_i);
    cfg_idx_i  <= REG_HEIGHT;
    cfg_data_i <= CFG_W'(h);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_w = (w == 0) ? 1 : ((w > LINE_MAX) ? LINE_MAX : w);
    cur_h = (h == 0) ? 1 : h;
  endtask

  // pattern: 0 random, 1 all zero, 2 all full scale, 3 both, alternating by pixel index
  function automatic in_t make_pixel(input int pattern, input int idx);
    in_t w;
    w.drain_tick = 1'b0;
    case (pattern)
      1: {w.sample_a, w.sample_b, w.sample_c} = '0;
      2: {w.sample_a, w.sample_b, w.sample_c} = '1;
      3: {w.sample_a, w.sample_b, w.sample_c} = (idx % 2) ? '1 : '0;
      default: begin
        w.sample_a = $urandom_range(255);
        w.sample_b = $urandom_range(255);
        w.sample_c = $urandom_range(255);
      end
    endcase
    return w;
  endfunction

  // one frame: pixels with stray drain words mixed in, then the flush, where
  // some flush words are pixel words that the block must treat as drain
  task automatic run_frame(input int pattern, input int noise_pct);
    in_t w;
    for (int i = 0; i < cur_w * cur_h; i++) begin
      if ($urandom_range(99) < noise_pct) begin
        w = make_pixel(0, i);
        w.drain_tick = 1'b1;
        push_word(w);
      end
      push_word(make_pixel(pattern, i));
    end
    for (int i = 0; i < 4 * cur_w + 4; i++) begin
      w = make_pixel(0, i);
      w.drain_tick = ($urandom_range(99) >= noise_pct);
      push_word(w);
    end
  endtask

  initial begin
    in_t w;
    int unsigned rw, rh;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes and the special cases
    configure(1'b0, 3, 2);
    run_frame(2, 20);
    // drain words after the frame end are ignored
    w = make_pixel(0, 0);
    w.drain_tick = 1'b1;
    push_word(w);
    push_word(w);
    configure(1'b1, 2, 2);
    run_frame(3, 0);
    run_frame(1, 0);
    // zero width and height act as one
    configure(1'b1, 0, 0);
    run_frame(2, 0);
    // partial frame, then a register write restarts it
    configure(1'b0, 5, 4);
    for (int i = 0; i < 6; i++) push_word(make_pixel(0, i));
    configure(1'b1, 5, 4);
    run_frame(0, 10);
    // width beyond the line store saturates; a partial row, then a restart
    configure(1'b0, 4095, 1);
    for (int i = 0; i < 8; i++) push_word(make_pixel(0, i));
    // one tall narrow frame, more rows than the line store slots
    configure(1'b1, 1, 40);
    run_frame(0, 0);

    // random frames, three idling phases
    items_sent = 0;
    for (int ph = 0; ph < 3; ph++) begin
      tx_idle = (ph == 0) ? 21 : ((ph == 1) ? 61 : 0);
      rx_idle = (ph == 0) ? 61 : ((ph == 1) ? 21 : 0);
      while (items_sent < (ph + 1) * 270) begin
        rw = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 12);
        rh = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 10);
        configure($urandom_range(1), rw, rh);
        if (ph == 2 && hold_left == 0 && items_sent < 700) hold_left = 400;
        run_frame(0, $urandom_range(1) ? 0 : 8);
        // sometimes a second frame back to back with no register write
        if ($urandom_range(2) == 0) run_frame(0, 0);
      end
    end

    pix_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
